/* src/pwc_pkg.sv */
// ----------------------------------------------------------------------------
// pwc_pkg
// Shared types and constants for the multi-channel pulse width capture block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pwc_pkg;

    // number of capture channels
    localparam int CHANNEL_COUNT = 6;
    localparam int CH_IDX_W      = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;

    // field widths
    localparam int CH_W    = 3;
    localparam int TIME_W  = 32;
    localparam int WIDTH_W = 16;
    localparam int CIDX_W  = 3;
    localparam int CDATA_W = 32;

    // configuration register indexes
    localparam logic [CIDX_W-1:0] REG_ACC_MIN  = 3'd0;
    localparam logic [CIDX_W-1:0] REG_ACC_MAX  = 3'd1;
    localparam logic [CIDX_W-1:0] REG_CLAMP_LO = 3'd2;
    localparam logic [CIDX_W-1:0] REG_CLAMP_HI = 3'd3;
    localparam logic [CIDX_W-1:0] REG_MID      = 3'd4;
    localparam logic [CIDX_W-1:0] REG_TIMEOUT  = 3'd5;

    // register reset values
    localparam logic [WIDTH_W-1:0] ACC_MIN_RST  = 16'd800;
    localparam logic [WIDTH_W-1:0] ACC_MAX_RST  = 16'd2200;
    localparam logic [WIDTH_W-1:0] CLAMP_LO_RST = 16'd1000;
    localparam logic [WIDTH_W-1:0] CLAMP_HI_RST = 16'd2000;
    localparam logic [WIDTH_W-1:0] MID_RST      = 16'd1500;
    localparam logic [TIME_W-1:0]  TIMEOUT_RST  = 32'd100000;

    // command codes
    localparam logic CMD_EDGE  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // configuration seen by the datapath
    typedef struct packed {
        logic [WIDTH_W-1:0] acc_min;
        logic [WIDTH_W-1:0] acc_max;
        logic [WIDTH_W-1:0] clamp_lo;
        logic [WIDTH_W-1:0] clamp_hi;
        logic [WIDTH_W-1:0] mid;
        logic [TIME_W-1:0]  timeout;
    } cfg_t;

    // one input item
    typedef struct packed {
        logic              cmd;
        logic [CH_W-1:0]   channel;
        logic              level;
        logic [TIME_W-1:0] now_us;
    } item_t;

    // one result item
    typedef struct packed {
        logic [WIDTH_W-1:0] width_us;
        logic               valid_res;
        logic               pulse_accepted;
    } result_t;

endpackage

/* src/pwc_cfg_regs.sv */
// ----------------------------------------------------------------------------
// pwc_cfg_regs
// Configuration register file, written through its own valid/ready channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pwc_cfg_regs
    import pwc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [CIDX_W-1:0]  cfg_index,
    input  logic [CDATA_W-1:0] cfg_data,
    output cfg_t               cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // writes are always taken
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // register decode, unknown indexes are dropped
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_ACC_MIN:  cfg_next.acc_min  = cfg_data[WIDTH_W-1:0];
                REG_ACC_MAX:  cfg_next.acc_max  = cfg_data[WIDTH_W-1:0];
                REG_CLAMP_LO: cfg_next.clamp_lo = cfg_data[WIDTH_W-1:0];
                REG_CLAMP_HI: cfg_next.clamp_hi = cfg_data[WIDTH_W-1:0];
                REG_MID:      cfg_next.mid      = cfg_data[WIDTH_W-1:0];
                REG_TIMEOUT:  cfg_next.timeout  = cfg_data[TIME_W-1:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.acc_min  <= ACC_MIN_RST;
            cfg_reg.acc_max  <= ACC_MAX_RST;
            cfg_reg.clamp_lo <= CLAMP_LO_RST;
            cfg_reg.clamp_hi <= CLAMP_HI_RST;
            cfg_reg.mid      <= MID_RST;
            cfg_reg.timeout  <= TIMEOUT_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* src/pwc_chan_state.sv */
// ----------------------------------------------------------------------------
// pwc_chan_state
// Per-channel capture state and the single-pass update and result logic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pwc_chan_state
    import pwc_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  cfg_t    cfg,
    input  item_t   item,
    input  logic    item_go,
    output result_t res
);

    logic [TIME_W-1:0]  rise_reg   [CHANNEL_COUNT];
    logic [WIDTH_W-1:0] width_reg  [CHANNEL_COUNT];
    logic [TIME_W-1:0]  upd_reg    [CHANNEL_COUNT];

    logic                in_range;
    logic [CH_IDX_W-1:0] idx;
    logic [TIME_W-1:0]   rise_cur;
    logic [WIDTH_W-1:0]  width_cur;
    logic [TIME_W-1:0]   upd_cur;
    logic [TIME_W-1:0]   dt;
    logic                is_rise;
    logic                is_fall;
    logic                accept;
    logic [WIDTH_W-1:0]  width_new;
    logic [TIME_W-1:0]   upd_new;
    logic [TIME_W-1:0]   age;
    logic [WIDTH_W-1:0]  width_clamped;

    // channel decode
    assign in_range  = ({1'b0, item.channel} < (CH_W + 1)'(CHANNEL_COUNT));
    assign idx       = in_range ? item.channel[CH_IDX_W-1:0] : '0;
    assign rise_cur  = rise_reg[idx];
    assign width_cur = width_reg[idx];
    assign upd_cur   = upd_reg[idx];

    // edge handling, wrapping pulse length against the accept window
    assign is_rise = (item.cmd == CMD_EDGE) && item.level;
    assign is_fall = (item.cmd == CMD_EDGE) && !item.level;
    assign dt      = item.now_us - rise_cur;
    assign accept  = is_fall
                   && (dt >= {{(TIME_W-WIDTH_W){1'b0}}, cfg.acc_min})
                   && (dt <= {{(TIME_W-WIDTH_W){1'b0}}, cfg.acc_max});

    assign width_new = accept ? dt[WIDTH_W-1:0] : width_cur;
    assign upd_new   = accept ? item.now_us : upd_cur;
    assign age       = item.now_us - upd_new;

    // clamp; with inverted limits, widths below the low limit get the low limit and all others the high limit
    always_comb begin
        if (width_new < cfg.clamp_lo) begin
            width_clamped = cfg.clamp_lo;
        end else if (width_new > cfg.clamp_hi) begin
            width_clamped = cfg.clamp_hi;
        end else begin
            width_clamped = width_new;
        end
    end

    // result for this item
    always_comb begin
        if (in_range) begin
            res.width_us       = width_clamped;
            res.valid_res      = (age < cfg.timeout);
            res.pulse_accepted = accept;
        end else begin
            res.width_us       = cfg.mid;
            res.valid_res      = 1'b0;
            res.pulse_accepted = 1'b0;
        end
    end

    // state update, lands with the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CHANNEL_COUNT; i++) begin
                rise_reg[i]  <= '0;
                width_reg[i] <= MID_RST;
                upd_reg[i]   <= '0;
            end
        end else if (item_go && in_range) begin
            if (is_rise) begin
                rise_reg[idx] <= item.now_us;
            end
            if (accept) begin
                width_reg[idx] <= dt[WIDTH_W-1:0];
                upd_reg[idx]   <= item.now_us;
            end
        end
    end

endmodule

/* src/multi_channel_pulse_width_capture.sv */
// ----------------------------------------------------------------------------
// multi_channel_pulse_width_capture
// Measures RC servo pulse widths on six channels. Each input item is an edge
// (channel, new level, microsecond time) or a query; every item returns one
// result item with the channel's clamped width, a freshness flag and whether
// this falling edge gave an accepted pulse. An item is registered on entry,
// worked through the per-channel state once the output register can take it
// and lands there, which raises m_valid. One item is taken every cycle while
// the output side keeps up; the output register lets a new item enter while a
// finished result waits to be taken.
// Configuration writes are taken every cycle and should only be issued while
// no item is in flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module multi_channel_pulse_width_capture
    import pwc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [CIDX_W-1:0]  cfg_index,
    input  logic [CDATA_W-1:0] cfg_data,

    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_cmd,
    input  logic [CH_W-1:0]    s_channel,
    input  logic               s_level,
    input  logic [TIME_W-1:0]  s_now_us,

    output logic               m_valid,
    input  logic               m_ready,
    output logic [WIDTH_W-1:0] m_width_us,
    output logic               m_valid_res,
    output logic               m_pulse_accepted
);

    cfg_t    cfg;
    item_t   item_reg;
    logic    item_vld_reg;
    logic    item_vld_next;
    result_t res;
    result_t res_reg;
    logic    res_vld_reg;
    logic    res_vld_next;
    logic    advance;
    logic    take_in;

    // configuration registers
    pwc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // flow control between input and output registers
    assign advance = item_vld_reg && (!res_vld_reg || m_ready);
    assign s_ready = !item_vld_reg || advance;
    assign take_in = s_valid && s_ready;

    assign item_vld_next = take_in ? 1'b1 : (advance ? 1'b0 : item_vld_reg);
    assign res_vld_next  = advance ? 1'b1 : ((res_vld_reg && m_ready) ? 1'b0 : res_vld_reg);

    // input item register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_vld_reg <= 1'b0;
        end else begin
            item_vld_reg <= item_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take_in) begin
            item_reg.cmd     <= s_cmd;
            item_reg.channel <= s_channel;
            item_reg.level   <= s_level;
            item_reg.now_us  <= s_now_us;
        end
    end

    // channel state and result logic
    pwc_chan_state u_state (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .item    (item_reg),
        .item_go (advance),
        .res     (res)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_vld_reg <= 1'b0;
        end else begin
            res_vld_reg <= res_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= res;
        end
    end

    assign m_valid          = res_vld_reg;
    assign m_width_us       = res_reg.width_us;
    assign m_valid_res      = res_reg.valid_res;
    assign m_pulse_accepted = res_reg.pulse_accepted;

endmodule

/* bench/multi_channel_pulse_width_capture_test.sv */
// ----------------------------------------------------------------------------
// multi_channel_pulse_width_capture_test
// Self-checking bench for the pulse width capture block. A short table of
// edge and query items opens the run, with hand-worked results for the
// plain cases. Random phases follow, each under a chosen register setting and
// idling pattern. Every accepted item runs through a local copy of the
// capture behaviour, and each result taken from the block is compared field
// by field with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module multi_channel_pulse_width_capture_test;
    import pwc_pkg::*;

    localparam int   QUIET_LIMIT      = 2000;
    localparam int   RANDOM_PER_PHASE = 165;
    localparam int   PHASE_COUNT      = 6;
    localparam logic LEVEL_HIGH       = 1'b1;
    localparam logic LEVEL_LOW        = 1'b0;

    // indexes past the last register, which the block must ignore
    localparam logic [CIDX_W-1:0] REG_UNUSED_A = 3'd6;
    localparam logic [CIDX_W-1:0] REG_UNUSED_B = 3'd7;

    // one row of the opening table
    typedef struct packed {
        item_t   stim;
        logic    pinned;
        result_t want;
    } row_t;

    logic               aclk      = 1'b0;
    logic               aresetn   = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [CIDX_W-1:0]  cfg_index = '0;
    logic [CDATA_W-1:0] cfg_data  = '0;
    logic               s_valid   = 1'b0;
    logic               s_ready;
    logic               s_cmd     = CMD_EDGE;
    logic [CH_W-1:0]    s_channel = '0;
    logic               s_level   = LEVEL_LOW;
    logic [TIME_W-1:0]  s_now_us  = '0;
    logic               m_valid;
    logic               m_ready   = 1'b0;
    logic [WIDTH_W-1:0] m_width_us;
    logic               m_valid_res;
    logic               m_pulse_accepted;

    // local copy of the capture state and registers
    cfg_t               model_cfg;
    logic [TIME_W-1:0]  rise_at    [CHANNEL_COUNT];
    logic [WIDTH_W-1:0] held_width [CHANNEL_COUNT];
    logic [TIME_W-1:0]  last_good  [CHANNEL_COUNT];

    result_t            expected_q [$];
    int                 mismatches  = 0;
    int                 items_sent  = 0;
    int                 quiet_cycles = 0;
    int                 sender_idle_pct = 0;
    int                 receiver_stall_pct = 0;
    logic [TIME_W-1:0]  clock_us = '0;

    multi_channel_pulse_width_capture dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_cmd            (s_cmd),
        .s_channel        (s_channel),
        .s_level          (s_level),
        .s_now_us         (s_now_us),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_width_us       (m_width_us),
        .m_valid_res      (m_valid_res),
        .m_pulse_accepted (m_pulse_accepted)
    );

    // 8 ns clock
    always #4 aclk = ~aclk;

    // predicted result of one item, updating the local channel state
    function automatic result_t measure_item(input item_t it);
        result_t            r;
        logic [TIME_W-1:0]  span;
        logic [WIDTH_W-1:0] held;
        r.pulse_accepted = 1'b0;
        if (it.channel >= CHANNEL_COUNT) begin
            r.width_us  = model_cfg.mid;
            r.valid_res = 1'b0;
            return r;
        end
        if (it.cmd == CMD_EDGE) begin
            if (it.level == LEVEL_HIGH) begin
                rise_at[it.channel] = it.now_us;
            end else begin
                span = it.now_us - rise_at[it.channel];
                if (span >= model_cfg.acc_min && span <= model_cfg.acc_max) begin
                    held_width[it.channel] = span[WIDTH_W-1:0];
                    last_good[it.channel]  = it.now_us;
                    r.pulse_accepted       = 1'b1;
                end
            end
        end
        // with inverted limits, widths below the low limit get the low limit and all others the high limit
        held = held_width[it.channel];
        if (held < model_cfg.clamp_lo) begin
            r.width_us = model_cfg.clamp_lo;
        end else if (held > model_cfg.clamp_hi) begin
            r.width_us = model_cfg.clamp_hi;
        end else begin
            r.width_us = held;
        end
        r.valid_res = (it.now_us - last_good[it.channel]) < model_cfg.timeout;
        return r;
    endfunction

    // offer one item, wait for it to be taken, then queue its prediction
    task automatic send_item(input item_t it, input logic pinned, input result_t want);
        result_t predicted;
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_cmd     <= it.cmd;
        s_channel <= it.channel;
        s_level   <= it.level;
        s_now_us  <= it.now_us;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predicted = measure_item(it);
        expected_q.push_back(pinned ? want : predicted);
        items_sent++;
    endtask

    // one register write; valid is left high for a following write
    task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CDATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            REG_ACC_MIN:  model_cfg.acc_min  = data[WIDTH_W-1:0];
            REG_ACC_MAX:  model_cfg.acc_max  = data[WIDTH_W-1:0];
            REG_CLAMP_LO: model_cfg.clamp_lo = data[WIDTH_W-1:0];
            REG_CLAMP_HI: model_cfg.clamp_hi = data[WIDTH_W-1:0];
            REG_MID:      model_cfg.mid      = data[WIDTH_W-1:0];
            REG_TIMEOUT:  model_cfg.timeout  = data[TIME_W-1:0];
            default: ;
        endcase
    endtask

    // stop offering items and let every outstanding result come back
    task automatic settle();
        s_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // mostly rise/fall pairs around the accept window, mixed with queries and noise
    task automatic random_burst(input int count);
        item_t             it;
        int                roll;
        int                stop;
        logic [TIME_W-1:0] span;
        logic [CH_W-1:0]   ch;
        stop = items_sent + count;
        while (items_sent < stop) begin
            roll = $urandom_range(99);
            ch   = CH_W'($urandom_range(CHANNEL_COUNT - 1));
            if (roll < 60) begin
                case ($urandom_range(9))
                    0:       span = TIME_W'(model_cfg.acc_min);
                    1:       span = TIME_W'(model_cfg.acc_max);
                    2:       span = TIME_W'(model_cfg.acc_min) - 1;
                    3:       span = TIME_W'(model_cfg.acc_max) + 1;
                    4:       span = $urandom;
                    5:       span = $urandom_range(65535);
                    default: span = $urandom_range(2400, 600);
                endcase
                clock_us += $urandom_range(3000, 20);
                it.cmd     = CMD_EDGE;
                it.channel = ch;
                it.level   = LEVEL_HIGH;
                it.now_us  = clock_us;
                send_item(it, 1'b0, '0);
                clock_us  += span;
                it.level   = LEVEL_LOW;
                it.now_us  = clock_us;
                send_item(it, 1'b0, '0);
            end else if (roll < 80) begin
                ch         = CH_W'($urandom_range(7));
                it.cmd     = CMD_QUERY;
                it.channel = ch;
                it.level   = 1'($urandom);
                // straddle the timeout boundary now and then
                if (ch < CHANNEL_COUNT && $urandom_range(3) == 0) begin
                    it.now_us = last_good[ch] + model_cfg.timeout - 1 + $urandom_range(2);
                end else begin
                    clock_us += $urandom_range(40000);
                    it.now_us = clock_us;
                end
                send_item(it, 1'b0, '0);
            end else begin
                it.cmd     = 1'($urandom);
                it.channel = CH_W'($urandom);
                it.level   = 1'($urandom);
                it.now_us  = $urandom;
                send_item(it, 1'b0, '0);
            end
        end
    endtask

    // receiver readiness
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // compare each taken result with the oldest prediction
    always @(posedge aclk) begin : result_check
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_q.size() == 0) begin
                $display("%0t unexpected item: expected none, actual %0d/%0b/%0b",
                         $time, m_width_us, m_valid_res, m_pulse_accepted);
                mismatches++;
            end else begin
                want = expected_q.pop_front();
                if (m_width_us !== want.width_us) begin
                    $display("%0t width_us: expected %0d, actual %0d",
                             $time, want.width_us, m_width_us);
                    mismatches++;
                end
                if (m_valid_res !== want.valid_res) begin
                    $display("%0t valid_res: expected %0b, actual %0b",
                             $time, want.valid_res, m_valid_res);
                    mismatches++;
                end
                if (m_pulse_accepted !== want.pulse_accepted) begin
                    $display("%0t pulse_accepted: expected %0b, actual %0b",
                             $time, want.pulse_accepted, m_pulse_accepted);
                    mismatches++;
                end
            end
        end
    end

    // watchdog on cycles with no handshake anywhere
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        row_t directed_rows [$];
        cfg_t next_cfg;

        // local state after reset
        model_cfg = '{acc_min: ACC_MIN_RST, acc_max: ACC_MAX_RST, clamp_lo: CLAMP_LO_RST,
                      clamp_hi: CLAMP_HI_RST, mid: MID_RST, timeout: TIMEOUT_RST};
        for (int i = 0; i < CHANNEL_COUNT; i++) begin
            rise_at[i]    = '0;
            held_width[i] = MID_RST;
            last_good[i]  = '0;
        end

        // opening table under reset settings
        directed_rows = '{
            // fresh after reset, then the timeout edge
            '{'{CMD_QUERY, 3'd0, LEVEL_LOW,  32'd0},          1'b1, '{16'd1500, 1'b1, 1'b0}},
            '{'{CMD_QUERY, 3'd5, LEVEL_LOW,  32'd99999},      1'b1, '{16'd1500, 1'b1, 1'b0}},
            '{'{CMD_QUERY, 3'd5, LEVEL_LOW,  32'd100000},     1'b1, '{16'd1500, 1'b0, 1'b0}},
            // channels out of range
            '{'{CMD_QUERY, 3'd6, LEVEL_LOW,  32'd0},          1'b1, '{16'd1500, 1'b0, 1'b0}},
            '{'{CMD_EDGE,  3'd7, LEVEL_HIGH, 32'hFFFF_FFFF},  1'b1, '{16'd1500, 1'b0, 1'b0}},
            // shortest accepted pulse, clamped up
            '{'{CMD_EDGE,  3'd0, LEVEL_HIGH, 32'd1000},       1'b1, '{16'd1500, 1'b1, 1'b0}},
            '{'{CMD_EDGE,  3'd0, LEVEL_LOW,  32'd1800},       1'b1, '{16'd1000, 1'b1, 1'b1}},
            // longest accepted pulse across the time wrap, clamped down
            '{'{CMD_EDGE,  3'd1, LEVEL_HIGH, 32'hFFFF_FC00},  1'b1, '{16'd1500, 1'b0, 1'b0}},
            '{'{CMD_EDGE,  3'd1, LEVEL_LOW,  32'd1176},       1'b1, '{16'd2000, 1'b1, 1'b1}},
            // one short of the window and one past it
            '{'{CMD_EDGE,  3'd2, LEVEL_HIGH, 32'd5000},       1'b1, '{16'd1500, 1'b1, 1'b0}},
            '{'{CMD_EDGE,  3'd2, LEVEL_LOW,  32'd5799},       1'b1, '{16'd1500, 1'b1, 1'b0}},
            '{'{CMD_EDGE,  3'd2, LEVEL_HIGH, 32'd10000},      1'b1, '{16'd1500, 1'b1, 1'b0}},
            '{'{CMD_EDGE,  3'd2, LEVEL_LOW,  32'd12201},      1'b1, '{16'd1500, 1'b1, 1'b0}},
            // plain pulse, then ageing out
            '{'{CMD_EDGE,  3'd3, LEVEL_HIGH, 32'd20000},      1'b1, '{16'd1500, 1'b1, 1'b0}},
            '{'{CMD_EDGE,  3'd3, LEVEL_LOW,  32'd21234},      1'b1, '{16'd1234, 1'b1, 1'b1}},
            '{'{CMD_QUERY, 3'd3, LEVEL_LOW,  32'd121233},     1'b1, '{16'd1234, 1'b1, 1'b0}},
            '{'{CMD_QUERY, 3'd3, LEVEL_HIGH, 32'd121234},     1'b1, '{16'd1234, 1'b0, 1'b0}},
            // falling edge with no rise seen
            '{'{CMD_EDGE,  3'd4, LEVEL_LOW,  32'd1500},       1'b1, '{16'd1500, 1'b1, 1'b1}},
            // query ignores level; stale channel
            '{'{CMD_QUERY, 3'd0, LEVEL_HIGH, 32'hFFFF_FFFF},  1'b1, '{16'd1000, 1'b0, 1'b0}},
            '{'{CMD_EDGE,  3'd5, LEVEL_LOW,  32'h7FFF_FFFF},  1'b1, '{16'd1500, 1'b0, 1'b0}},
            '{'{CMD_QUERY, 3'd1, LEVEL_LOW,  32'd1276},       1'b1, '{16'd2000, 1'b1, 1'b0}},
            // repeated rise on a measured channel, left to the predictor
            '{'{CMD_EDGE,  3'd3, LEVEL_HIGH, 32'd130000},     1'b0, '0}
        };

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < directed_rows.size(); i++) begin
            send_item(directed_rows[i].stim, directed_rows[i].pinned, directed_rows[i].want);
        end

        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            case (phase % 4)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 46; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 46; end
                default: begin sender_idle_pct = 12; receiver_stall_pct = 12; end
            endcase
            if (phase > 0) begin
                case (phase)
                    // widest window and limits, longest timeout
                    1: next_cfg = '{acc_min: 16'd0, acc_max: 16'hFFFF, clamp_lo: 16'd0,
                                    clamp_hi: 16'hFFFF, mid: 16'd0, timeout: 32'hFFFF_FFFF};
                    // inverted window and limits, every channel stale
                    2: next_cfg = '{acc_min: 16'd2000, acc_max: 16'd1000, clamp_lo: 16'd2000,
                                    clamp_hi: 16'd1000, mid: 16'hFFFF, timeout: 32'd0};
                    // single-value window and limits
                    3: next_cfg = '{acc_min: 16'd1500, acc_max: 16'd1500, clamp_lo: 16'd1500,
                                    clamp_hi: 16'd1500, mid: 16'd1500, timeout: 32'd1};
                    4: begin
                        next_cfg.acc_min  = WIDTH_W'($urandom_range(1200, 400));
                        next_cfg.acc_max  = WIDTH_W'(next_cfg.acc_min + $urandom_range(2000));
                        next_cfg.clamp_lo = WIDTH_W'($urandom_range(1400, 600));
                        next_cfg.clamp_hi = WIDTH_W'(next_cfg.clamp_lo + $urandom_range(1200));
                        next_cfg.mid      = WIDTH_W'($urandom_range(65535));
                        next_cfg.timeout  = $urandom_range(200000, 500);
                    end
                    default: next_cfg = '{acc_min: ACC_MIN_RST, acc_max: ACC_MAX_RST,
                                          clamp_lo: CLAMP_LO_RST, clamp_hi: CLAMP_HI_RST,
                                          mid: MID_RST, timeout: TIMEOUT_RST};
                endcase
                settle();
                write_reg(REG_ACC_MIN,  CDATA_W'(next_cfg.acc_min));
                write_reg(REG_ACC_MAX,  CDATA_W'(next_cfg.acc_max));
                write_reg(REG_CLAMP_LO, CDATA_W'(next_cfg.clamp_lo));
                write_reg(REG_CLAMP_HI, CDATA_W'(next_cfg.clamp_hi));
                write_reg(REG_MID,      CDATA_W'(next_cfg.mid));
                write_reg(REG_TIMEOUT,  next_cfg.timeout);
                write_reg(REG_UNUSED_A, $urandom);
                write_reg(REG_UNUSED_B, $urandom);
                cfg_valid <= 1'b0;
            end
            // odd phases start just short of the time wrap
            if (phase % 2 == 1) begin
                clock_us = 32'hFFFF_0000 + $urandom_range(65535);
            end else begin
                clock_us = $urandom_range(200000);
            end
            random_burst(RANDOM_PER_PHASE);
        end

        settle();
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
